>>> rtl/eisc_pkg.sv
`default_nettype none
package eisc_pkg;

  localparam int WordW     = 16;
  localparam int IntervalW = 14;
  localparam int DataW     = 32;
  localparam int KindW     = 3;
  localparam int QueueDepthDefault = 2;

  localparam logic [IntervalW-1:0] TimeMask = 14'h3FFF;
  localparam int Ch1Bit = 14;
  localparam int Ch2Bit = 15;

  localparam logic [DataW-1:0] SeqRestart = 32'd2;
  localparam logic [DataW-1:0] FirstEvent = 32'd1;
  localparam logic [DataW-1:0] SecondEvent = 32'd2;

  typedef enum logic [KindW-1:0] {
    KIND_NONE     = 3'd0,
    KIND_ROLLOVER = 3'd1,
    KIND_DUAL     = 3'd2,
    KIND_CH1      = 3'd3,
    KIND_MISMATCH = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    WC_ROLL_OK,
    WC_ROLL_BAD,
    WC_DUAL,
    WC_CH1,
    WC_CH2
  } word_class_t;

  typedef struct packed {
    word_class_t           wclass;
    logic                  block_start;
    logic [IntervalW-1:0]  interval;
  } item_t;

  typedef struct packed {
    kind_t              kind;
    logic [DataW-1:0]   interval_sum;
    logic [DataW-1:0]   event_total;
    logic [DataW-1:0]   block_error_total;
  } result_t;

endpackage
`default_nettype wire

>>> rtl/eisc_queue.sv
`default_nettype none
module eisc_queue #(
  parameter int Width = 8,
  parameter int Depth = eisc_pkg::QueueDepthDefault
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [Width-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic      [Width-1:0] rd_data,
  output logic                  empty
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem [Depth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_wr;
  logic             do_rd;

  assign full  = (count == CntW'(Depth));
  assign empty = (count == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/eisc_front.sv
`default_nettype none
module eisc_front (
  input  wire logic [eisc_pkg::WordW-1:0]     word,
  input  wire logic                           block_start,
  input  wire logic                           push,
  input  wire logic [eisc_pkg::IntervalW-1:0] rollover_interval,
  input  wire logic                           q_full,
  output logic                                q_wr,
  output eisc_pkg::item_t                     q_item
);

  logic [eisc_pkg::IntervalW-1:0] interval;
  logic                           ch1;
  logic                           ch2;

  assign interval = word[eisc_pkg::IntervalW-1:0] & eisc_pkg::TimeMask;
  assign ch1      = word[eisc_pkg::Ch1Bit];
  assign ch2      = word[eisc_pkg::Ch2Bit];
  assign q_wr     = push && !q_full;

  always_comb begin
    q_item.block_start = block_start;
    q_item.interval    = interval;
    unique case ({ch2, ch1})
      2'b00:   q_item.wclass = (interval == rollover_interval) ? eisc_pkg::WC_ROLL_OK
                                                               : eisc_pkg::WC_ROLL_BAD;
      2'b11:   q_item.wclass = eisc_pkg::WC_DUAL;
      2'b01:   q_item.wclass = eisc_pkg::WC_CH1;
      default: q_item.wclass = eisc_pkg::WC_CH2;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/eisc_back.sv
`default_nettype none
module eisc_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [eisc_pkg::DataW-1:0] max_sequence_value,
  input  wire eisc_pkg::item_t            q_item,
  input  wire logic                       q_empty,
  output logic                            q_rd,
  input  wire logic                       res_full,
  output logic                            res_wr,
  output eisc_pkg::result_t               res
);

  localparam int DW = eisc_pkg::DataW;

  logic [DW-1:0] running_interval;
  logic [DW-1:0] running_interval_next;
  logic [DW-1:0] event_counter;
  logic [DW-1:0] event_counter_next;
  logic [DW-1:0] expected_value;
  logic [DW-1:0] expected_value_next;
  logic [DW-1:0] block_errors;
  logic [DW-1:0] block_errors_next;

  logic [DW:0]   sum_wide;
  logic [DW-1:0] sum;
  logic [DW-1:0] count_inc;
  logic [DW-1:0] block_base;
  logic          is_event;
  logic          first_two;
  eisc_pkg::kind_t kind;

  assign q_rd   = !q_empty && !res_full;
  assign res_wr = q_rd;

  assign sum_wide  = {1'b0, running_interval} + {{(DW + 1 - eisc_pkg::IntervalW){1'b0}},
                                                 q_item.interval};
  assign sum       = sum_wide[DW] ? '1 : sum_wide[DW-1:0];
  assign count_inc = event_counter + 1'b1;
  assign is_event  = (q_item.wclass != eisc_pkg::WC_ROLL_OK) &&
                     (q_item.wclass != eisc_pkg::WC_ROLL_BAD);
  assign first_two = (count_inc == eisc_pkg::FirstEvent) ||
                     (count_inc == eisc_pkg::SecondEvent);

  always_comb begin
    kind                = eisc_pkg::KIND_NONE;
    expected_value_next = expected_value;
    unique case (q_item.wclass)
      eisc_pkg::WC_ROLL_OK:  kind = eisc_pkg::KIND_NONE;
      eisc_pkg::WC_ROLL_BAD: kind = eisc_pkg::KIND_ROLLOVER;
      eisc_pkg::WC_DUAL:     kind = eisc_pkg::KIND_DUAL;
      eisc_pkg::WC_CH1:      kind = eisc_pkg::KIND_CH1;
      eisc_pkg::WC_CH2: begin
        if (!first_two && (sum != expected_value)) begin
          kind = eisc_pkg::KIND_MISMATCH;
        end
        if (count_inc != eisc_pkg::FirstEvent) begin
          expected_value_next = (sum < max_sequence_value) ? sum + 1'b1
                                                           : eisc_pkg::SeqRestart;
        end
      end
      default: kind = eisc_pkg::KIND_NONE;
    endcase
  end

  assign block_base            = q_item.block_start ? '0 : block_errors;
  assign block_errors_next     = block_base + DW'(kind != eisc_pkg::KIND_NONE);
  assign event_counter_next    = is_event ? count_inc : event_counter;
  assign running_interval_next = is_event ? '0 : sum;

  always_comb begin
    res.kind              = kind;
    res.interval_sum      = sum;
    res.event_total       = event_counter_next;
    res.block_error_total = block_errors_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_interval <= '0;
      event_counter    <= '0;
      expected_value   <= '0;
      block_errors     <= '0;
    end else if (q_rd) begin
      running_interval <= running_interval_next;
      event_counter    <= event_counter_next;
      expected_value   <= expected_value_next;
      block_errors     <= block_errors_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/event_interval_sequence_checker.sv
// Event interval sequence checker.
// Input channel: push/full queue of timer words (word, block_start); a
// transaction completes on a clock edge with push high and full low.
// Result channel: empty/pop queue; the oldest result sits on error_kind,
// interval_sum, event_total and block_error_total while empty is low and
// leaves on an edge with pop high and empty low.
// Configuration: APB-style writes, max_sequence_value at 0x0 and
// rollover_interval at 0x4; pready is tied high, reads return the value.
// A word accepted on an edge is classified and registered in a QueueDepth-entry
// word queue ahead of the checking stage; that stage reads it while the result
// queue is not full and registers its result in a QueueDepth-entry result queue.
// Throughput: one word per cycle while the result queue has room; the checking
// stage does its state update (saturating add, compare, count) for each word.
// Reset (synchronous, rst high) empties both queues, clears the sum and all
// counts, and loads max_sequence_value 0 and rollover_interval 0x3FFF.
// When the receiver stalls, the result queue fills, the checking stage
// holds, the word queue fills and full rises; no transaction is lost.
`default_nettype none
module event_interval_sequence_checker #(
  parameter int QueueDepth = eisc_pkg::QueueDepthDefault
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [2:0]                          paddr,
  input  wire logic [eisc_pkg::DataW-1:0]          pwdata,
  output logic      [eisc_pkg::DataW-1:0]          prdata,
  output logic                                     pready,
  input  wire logic [eisc_pkg::WordW-1:0]          word,
  input  wire logic                                block_start,
  input  wire logic                                push,
  output logic                                     full,
  output logic      [eisc_pkg::KindW-1:0]          error_kind,
  output logic      [eisc_pkg::DataW-1:0]          interval_sum,
  output logic      [eisc_pkg::DataW-1:0]          event_total,
  output logic      [eisc_pkg::DataW-1:0]          block_error_total,
  output logic                                     empty,
  input  wire logic                                pop
);

  localparam logic RegMaxSeq   = 1'b0;
  localparam logic RegRollover = 1'b1;
  localparam int ItemW   = $bits(eisc_pkg::item_t);
  localparam int ResultW = $bits(eisc_pkg::result_t);

  logic [eisc_pkg::DataW-1:0]     max_sequence_value;
  logic [eisc_pkg::IntervalW-1:0] rollover_interval;
  logic                           reg_sel;
  logic                           cfg_wr;

  logic              mid_wr;
  logic              mid_full;
  logic              mid_rd;
  logic              mid_empty;
  eisc_pkg::item_t   mid_in;
  eisc_pkg::item_t   mid_out;
  logic [ItemW-1:0]  mid_out_bits;

  logic              res_wr;
  logic              res_full;
  eisc_pkg::result_t res_in;
  eisc_pkg::result_t res_out;
  logic [ResultW-1:0] res_out_bits;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_sequence_value <= '0;
      rollover_interval  <= eisc_pkg::TimeMask;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        RegMaxSeq:   max_sequence_value <= pwdata;
        RegRollover: rollover_interval  <= pwdata[eisc_pkg::IntervalW-1:0];
        default:     max_sequence_value <= max_sequence_value;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegMaxSeq:   prdata = max_sequence_value;
      RegRollover: prdata = {{(eisc_pkg::DataW - eisc_pkg::IntervalW){1'b0}},
                             rollover_interval};
      default:     prdata = '0;
    endcase
  end

  eisc_front u_front (
    .word              (word),
    .block_start       (block_start),
    .push              (push),
    .rollover_interval (rollover_interval),
    .q_full            (mid_full),
    .q_wr              (mid_wr),
    .q_item            (mid_in)
  );

  assign full = mid_full;

  eisc_queue #(
    .Width (ItemW),
    .Depth (QueueDepth)
  ) u_mid_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (mid_wr),
    .wr_data (mid_in),
    .full    (mid_full),
    .rd_en   (mid_rd),
    .rd_data (mid_out_bits),
    .empty   (mid_empty)
  );

  assign mid_out = eisc_pkg::item_t'(mid_out_bits);

  eisc_back u_back (
    .clk                (clk),
    .rst                (rst),
    .max_sequence_value (max_sequence_value),
    .q_item             (mid_out),
    .q_empty            (mid_empty),
    .q_rd               (mid_rd),
    .res_full           (res_full),
    .res_wr             (res_wr),
    .res                (res_in)
  );

  eisc_queue #(
    .Width (ResultW),
    .Depth (QueueDepth)
  ) u_res_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_wr),
    .wr_data (res_in),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_out_bits),
    .empty   (empty)
  );

  assign res_out           = eisc_pkg::result_t'(res_out_bits);
  assign error_kind        = res_out.kind;
  assign interval_sum      = res_out.interval_sum;
  assign event_total       = res_out.event_total;
  assign block_error_total = res_out.block_error_total;

endmodule
`default_nettype wire

>>> tb/event_interval_sequence_checker_monitor.sv
module event_interval_sequence_checker_monitor #(
  parameter logic [2:0] MaxSeqAddr   = 3'd0,
  parameter logic [2:0] RolloverAddr = 3'd4
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [2:0]                          paddr,
  input  wire logic [eisc_pkg::DataW-1:0]          pwdata,
  input  wire logic [eisc_pkg::DataW-1:0]          prdata,
  input  wire logic                                pready,
  input  wire logic [eisc_pkg::WordW-1:0]          word,
  input  wire logic                                block_start,
  input  wire logic                                push,
  input  wire logic                                full,
  input  wire logic [eisc_pkg::KindW-1:0]          error_kind,
  input  wire logic [eisc_pkg::DataW-1:0]          interval_sum,
  input  wire logic [eisc_pkg::DataW-1:0]          event_total,
  input  wire logic [eisc_pkg::DataW-1:0]          block_error_total,
  input  wire logic                                empty,
  input  wire logic                                pop,
  output int                                       failures,
  output int                                       pending,
  output int                                       checked,
  output int                                       flagged
);
  import eisc_pkg::*;

  logic [DataW-1:0]     seq_limit;
  logic [IntervalW-1:0] rollover_ok;
  logic [DataW-1:0]     run_sum;
  logic [DataW-1:0]     evt_count;
  logic [DataW-1:0]     seq_expect;
  logic [DataW-1:0]     blk_err;
  result_t              due_q[$];

  function automatic result_t classify_word(input logic [WordW-1:0] w, input logic s);
    result_t              r;
    logic [IntervalW-1:0] ival;
    logic [DataW:0]       wide;
    logic                 one;
    logic                 two;
    ival = w[IntervalW-1:0];
    one = w[Ch1Bit];
    two = w[Ch2Bit];
    r.kind = KIND_NONE;
    if (s) blk_err = '0;
    wide = {1'b0, run_sum} + ival;
    run_sum = wide[DataW] ? '1 : wide[DataW-1:0];
    r.interval_sum = run_sum;
    if (!one && !two) begin
      if (ival != rollover_ok) r.kind = KIND_ROLLOVER;
    end else begin
      evt_count = evt_count + 1;
      if (one && two) begin
        r.kind = KIND_DUAL;
      end else if (one) begin
        r.kind = KIND_CH1;
      end else if (evt_count != FirstEvent) begin
        if (evt_count != SecondEvent && r.interval_sum != seq_expect) r.kind = KIND_MISMATCH;
        seq_expect = (r.interval_sum < seq_limit) ? r.interval_sum + 1 : SeqRestart;
      end
      run_sum = '0;
    end
    if (r.kind != KIND_NONE) blk_err = blk_err + 1;
    r.event_total = evt_count;
    r.block_error_total = blk_err;
    return r;
  endfunction

  function automatic void compare_field(input string what, input logic [DataW-1:0] want,
                                        input logic [DataW-1:0] got);
    if (got !== want) begin
      failures++;
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin : watch
    result_t due;
    if (rst) begin
      seq_limit = '0;
      rollover_ok = TimeMask;
      run_sum = '0;
      evt_count = '0;
      seq_expect = '0;
      blk_err = '0;
      due_q.delete();
      pending = 0;
      failures = 0;
      checked = 0;
      flagged = 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == MaxSeqAddr) seq_limit = pwdata;
          else if (paddr == RolloverAddr) rollover_ok = pwdata[IntervalW-1:0];
        end else if (paddr == MaxSeqAddr) begin
          compare_field("max_sequence_value read", seq_limit, prdata);
        end else if (paddr == RolloverAddr) begin
          compare_field("rollover_interval read", {{(DataW-IntervalW){1'b0}}, rollover_ok},
                        prdata);
        end
      end
      if (pop && !empty) begin
        if (due_q.size() == 0) begin
          failures++;
          $display("%0t: result with nothing outstanding, kind %0d sum %0d", $time,
                   error_kind, interval_sum);
        end else begin
          due = due_q.pop_front();
          checked++;
          if (due.kind != KIND_NONE) flagged++;
          compare_field("error_kind", {{(DataW-KindW){1'b0}}, due.kind},
                        {{(DataW-KindW){1'b0}}, error_kind});
          compare_field("interval_sum", due.interval_sum, interval_sum);
          compare_field("event_total", due.event_total, event_total);
          compare_field("block_error_total", due.block_error_total, block_error_total);
        end
      end
      if (push && !full) due_q.push_back(classify_word(word, block_start));
      pending = due_q.size();
    end
  end

endmodule

>>> tb/event_interval_sequence_checker_test.sv
module event_interval_sequence_checker_test;
  import eisc_pkg::*;

  localparam logic [2:0] MaxSeqAddr    = 3'd0;
  localparam logic [2:0] RolloverAddr  = 3'd4;
  localparam logic [1:0] FlagNone      = 2'b00;
  localparam logic [1:0] FlagCh1       = 2'b01;
  localparam logic [1:0] FlagCh2       = 2'b10;
  localparam logic [1:0] FlagBoth      = 2'b11;
  localparam longint     IntervalMax   = 16383;
  localparam int         PhaseWords    = 150;
  localparam int         CycleLimit    = 2_000_000;

  logic                 clk;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [2:0]           paddr;
  logic [DataW-1:0]     pwdata;
  logic [DataW-1:0]     prdata;
  logic                 pready;
  logic [WordW-1:0]     word;
  logic                 block_start;
  logic                 push;
  logic                 full;
  logic [KindW-1:0]     error_kind;
  logic [DataW-1:0]     interval_sum;
  logic [DataW-1:0]     event_total;
  logic [DataW-1:0]     block_error_total;
  logic                 empty;
  logic                 pop = 1'b0;
  int                   failures;
  int                   pending;
  int                   checked;
  int                   flagged;

  logic                 calm;
  logic [DataW-1:0]     seq_limit_set;
  logic [IntervalW-1:0] rollover_set;
  longint unsigned      acc;
  logic [DataW-1:0]     target;
  int                   settings = 0;
  int                   cycles = 0;

  event_interval_sequence_checker u_dut (.*);

  event_interval_sequence_checker_monitor #(
    .MaxSeqAddr  (MaxSeqAddr),
    .RolloverAddr(RolloverAddr)
  ) u_monitor (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("event_interval_sequence_checker regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) pop <= 1'b0;
    else pop <= calm || ($urandom_range(99) >= 17);
  end

  // track the sum the stream has built and the sum the next event should carry
  function automatic void follow_word(input logic [WordW-1:0] w);
    longint unsigned s;
    s = acc + w[IntervalW-1:0];
    if (s > 64'hFFFF_FFFF) s = 64'hFFFF_FFFF;
    if (w[Ch1Bit] || w[Ch2Bit]) begin
      if (w[Ch2Bit] && !w[Ch1Bit]) target = (s < seq_limit_set) ? s[DataW-1:0] + 1 : SeqRestart;
      acc = 0;
    end else begin
      acc = s;
    end
  endfunction

  function automatic logic [WordW-1:0] aimed_word();
    longint               gap;
    logic [IntervalW-1:0] ival;
    gap = longint'(target) - longint'(acc);
    ival = gap[IntervalW-1:0];
    if (gap > IntervalMax && rollover_set >= 14'd1024) return {FlagNone, rollover_set};
    if (gap < 0 || gap > IntervalMax) ival = $urandom_range(IntervalMax);
    return {FlagCh2, ival};
  endfunction

  task automatic put_word(input logic [WordW-1:0] w, input logic s);
    while (!calm && $urandom_range(99) < 17) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    word <= w;
    block_start <= s;
    @(posedge clk);
    while (full) @(posedge clk);
    follow_word(w);
  endtask

  task automatic bus_access(input logic wr, input logic [2:0] addr, input logic [DataW-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // hold off until every outstanding transaction has come back
  task automatic drain();
    push <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [DataW-1:0] limit, input logic [DataW-1:0] roll);
    drain();
    bus_access(1'b1, MaxSeqAddr, limit);
    bus_access(1'b1, RolloverAddr, roll);
    bus_access(1'b0, MaxSeqAddr, '0);
    bus_access(1'b0, RolloverAddr, '0);
    seq_limit_set = limit;
    rollover_set = roll[IntervalW-1:0];
    settings++;
  endtask

  task automatic random_words(input int n);
    logic [WordW-1:0] w;
    int               pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 70) w = aimed_word();
      else if (pick < 75) w = {FlagNone, rollover_set};
      else w = $urandom_range(65535);
      put_word(w, $urandom_range(15) == 0);
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    word = '0;
    block_start = 1'b0;
    push = 1'b0;
    calm = 1'b0;
    acc = 0;
    target = '0;
    seq_limit_set = '0;
    rollover_set = TimeMask;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    bus_access(1'b0, MaxSeqAddr, '0);
    bus_access(1'b0, RolloverAddr, '0);
    put_word({FlagNone, TimeMask}, 1'b1);
    put_word({FlagNone, 14'd0}, 1'b0);
    put_word({FlagNone, 14'h1234}, 1'b0);
    put_word({FlagCh2, 14'd5}, 1'b0);
    put_word({FlagCh2, 14'd10}, 1'b0);
    put_word({FlagCh2, 14'd2}, 1'b0);
    put_word({FlagCh2, 14'd3}, 1'b0);
    put_word({FlagBoth, TimeMask}, 1'b0);
    put_word({FlagCh1, 14'd1}, 1'b0);
    put_word({FlagCh2, 14'd2}, 1'b1);
    put_word({FlagBoth, 14'd0}, 1'b0);
    put_word({FlagCh1, TimeMask}, 1'b1);
    put_word({FlagCh2, TimeMask}, 1'b0);
    put_word({FlagNone, 14'h2AAA}, 1'b0);
    put_word({FlagCh2, 14'h1555}, 1'b1);

    apply_setting(32'hFFFF_FFFF, 32'h0);
    random_words(PhaseWords);
    apply_setting($urandom_range(60, 2), $urandom);
    random_words(PhaseWords);
    apply_setting($urandom, {18'h3FFFF, TimeMask});
    calm = 1'b1;
    random_words(PhaseWords);
    calm = 1'b0;
    apply_setting(32'h0, $urandom);
    random_words(PhaseWords);
    apply_setting($urandom_range(40000, 100), $urandom_range(16383, 1024));
    random_words(PhaseWords);

    // finish with a short stretch and no idling on either side
    apply_setting($urandom, {18'h0, TimeMask});
    calm = 1'b1;
    put_word({FlagNone, 14'd7}, 1'b0);
    put_word({FlagCh2, TimeMask}, 1'b0);
    put_word({FlagCh2, 14'd1}, 1'b0);
    calm = 1'b0;
    random_words(20);

    drain();
    repeat (4) @(posedge clk);
    @(negedge clk);
    $display("Checked %0d results (%0d with an error kind) under %0d register settings.",
             checked, flagged, settings);
    $display("Covered all word classes, block restarts, sequence wraps and register reads.");
    if (failures == 0) begin
      $display("event_interval_sequence_checker regression: pass");
    end else begin
      $display("event_interval_sequence_checker regression: fail");
    end
    $finish;
  end

endmodule
